[rtl/core/gra_pkg.sv]
// Package for the guillotine rectangle allocator.
// Holds sizes, the free-rectangle entry type, state and status codes.
// Used by guillotine_rect_allocator and the testbench; depends on nothing.
package gra_pkg;

   localparam int MAX_FREE   = 64;
   localparam int COORD_BITS = 13;
   localparam int IDX_W      = $clog2(MAX_FREE);
   localparam int CNT_W      = $clog2(MAX_FREE + 1);
   localparam int DATA_W     = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int ENTRY_W    = 4 * COORD_BITS;

   localparam logic [COORD_BITS-1:0] BIN_RESET = COORD_BITS'(1024);

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type left;
      coord_type top;
      coord_type right;
      coord_type bottom;
   } free_rect_type;

   typedef enum logic [1:0] {
      STATUS_PLACED  = 2'd0,
      STATUS_DROPPED = 2'd1,
      STATUS_NOFIT   = 2'd2,
      STATUS_CLEARED = 2'd3
   } status_type;

   typedef enum logic {
      REQ_PACK  = 1'b0,
      REQ_CLEAR = 1'b1
   } req_kind_type;

   typedef enum logic {
      CSR_BIN_WIDTH  = 1'b0,
      CSR_BIN_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_DECIDE,
      ST_COMPACT,
      ST_CUT_KEEP,
      ST_CUT_NEW,
      ST_DONE
   } gra_state_type;

endpackage

[rtl/core/guillotine_rect_allocator.sv]
// Top level of the guillotine rectangle allocator: sequencer, free-list
// scan unit and result register. Depends on gra_pkg and gra_ram.
//
//   Channel | Direction | Payload
//   --------+-----------+---------------------------------------------------
//   req_    | in        | tuser: req_type; tdata: rect_width, rect_height
//   rsp_    | out       | tuser: status;   tdata: pos_x, pos_y
//   csr_    | in        | index 0 bin_width, 1 bin_height
//
// A clear writes the whole-bin entry in ST_CLEAR; a pack scans N free entries
// in ST_SCAN, one entry a cycle through the single read port of the free-list
// RAM; ST_DECIDE then ends on no fit, cuts in ST_CUT_KEEP and, if the cut
// appends an entry, ST_CUT_NEW, or moves later entries down in ST_COMPACT on
// an exact fit. After reset ST_INIT writes the whole-bin entry. It takes one
// item at a time; a waiting result stalls only the next item's completion.
module guillotine_rect_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [gra_pkg::DATA_W-1:0]    req_tdata,   // rect_width, rect_height
   input  logic                          req_tuser,   // req_type
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [gra_pkg::DATA_W-1:0]    rsp_tdata,   // pos_x, pos_y
   output logic [1:0]                    rsp_tuser,   // status
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [gra_pkg::COORD_BITS-1:0] csr_wdata
);
   import gra_pkg::*;

   gra_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_addr_ff, pend_addr_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   coord_type        best_rw_ff, best_rw_in;
   coord_type        best_rh_ff, best_rh_in;
   free_rect_type    best_ent_ff, best_ent_in;
   coord_type        w_ff, w_in;
   coord_type        h_ff, h_in;
   status_type       res_status_ff, res_status_in;
   coord_type        res_x_ff, res_x_in;
   coord_type        res_y_ff, res_y_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   coord_type        rsp_x_ff, rsp_x_in;
   coord_type        rsp_y_ff, rsp_y_in;
   coord_type        bin_w_ff, bin_h_ff;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   free_rect_type    ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   free_rect_type    rd_ent;

   coord_type        fw, fh, rw, rh, pr, pb;
   logic             fits, better;

   gra_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_FREE)
   ) u_free_list (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign rd_ent = free_rect_type'(ram_rdata);

   // Shared fit-and-rank unit for the entry read in the previous cycle.
   always_comb begin
      fw     = rd_ent.right - rd_ent.left;
      fh     = rd_ent.bottom - rd_ent.top;
      fits   = (w_ff <= fw) && (h_ff <= fh);
      rw     = fw - w_ff;
      rh     = fh - h_ff;
      better = !found_ff || (rw < best_rw_ff) || ((rw == best_rw_ff) && (rh < best_rh_ff));
      pr     = best_ent_ff.left + w_ff;
      pb     = best_ent_ff.top + h_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_w_ff <= BIN_RESET;
         bin_h_ff <= BIN_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_BIN_WIDTH:  bin_w_ff <= csr_wdata;
            CSR_BIN_HEIGHT: bin_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         count_ff     <= CNT_W'(1);
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      pend_addr_ff  <= pend_addr_in;
      best_idx_ff   <= best_idx_in;
      best_rw_ff    <= best_rw_in;
      best_rh_ff    <= best_rh_in;
      best_ent_ff   <= best_ent_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      res_status_ff <= res_status_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_rw_in    = best_rw_ff;
      best_rh_in    = best_rh_ff;
      best_ent_in   = best_ent_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      res_status_in = res_status_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = idx_ff[IDX_W-1:0];
      req_tready    = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            ram_we          = 1'b1;
            ram_wdata.right = BIN_RESET;
            ram_wdata.bottom = BIN_RESET;
            state_in        = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               w_in     = req_tdata[COORD_BITS-1:0];
               h_in     = req_tdata[2*COORD_BITS-1:COORD_BITS];
               idx_in   = '0;
               pend_in  = 1'b0;
               found_in = 1'b0;
               if (req_kind_type'(req_tuser) == REQ_CLEAR) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_CLEAR: begin
            ram_we           = 1'b1;
            ram_wdata.right  = bin_w_ff;
            ram_wdata.bottom = bin_h_ff;
            count_in         = CNT_W'(1);
            res_status_in    = STATUS_CLEARED;
            res_x_in         = '0;
            res_y_in         = '0;
            state_in         = ST_DONE;
         end
         ST_SCAN: begin
            if (pend_ff && fits && better) begin
               found_in    = 1'b1;
               best_idx_in = pend_addr_ff;
               best_rw_in  = rw;
               best_rh_in  = rh;
               best_ent_in = rd_ent;
            end
            if (idx_ff < count_ff) begin
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[IDX_W-1:0];
               idx_in       = idx_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            res_x_in      = found_ff ? best_ent_ff.left : '0;
            res_y_in      = found_ff ? best_ent_ff.top : '0;
            res_status_in = found_ff ? STATUS_PLACED : STATUS_NOFIT;
            if (!found_ff) begin
               state_in = ST_DONE;
            end else if ((best_rw_ff == '0) && (best_rh_ff == '0)) begin
               count_in = count_ff - CNT_W'(1);
               idx_in   = CNT_W'(best_idx_ff) + CNT_W'(1);
               pend_in  = 1'b0;
               state_in = ST_COMPACT;
            end else begin
               state_in = ST_CUT_KEEP;
            end
         end
         ST_COMPACT: begin
            // count_ff already holds the reduced size, so the last source
            // entry sits at index count_ff.
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_addr_ff;
               ram_wdata = rd_ent;
            end
            if (idx_ff <= count_ff && idx_ff < CNT_W'(MAX_FREE)) begin
               pend_in      = 1'b1;
               pend_addr_in = IDX_W'(idx_ff - CNT_W'(1));
               idx_in       = idx_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CUT_KEEP: begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_ff;
            ram_wdata = best_ent_ff;
            if (best_rw_ff > best_rh_ff) begin
               ram_wdata.left = pr;
            end else begin
               ram_wdata.top = pb;
            end
            state_in = ST_DONE;
            if ((best_rw_ff != '0) && (best_rh_ff != '0)) begin
               if (count_ff < CNT_W'(MAX_FREE)) begin
                  state_in = ST_CUT_NEW;
               end else begin
                  res_status_in = STATUS_DROPPED;
               end
            end
         end
         ST_CUT_NEW: begin
            ram_we    = 1'b1;
            ram_waddr = count_ff[IDX_W-1:0];
            if (best_rw_ff > best_rh_ff) begin
               ram_wdata.left   = best_ent_ff.left;
               ram_wdata.top    = pb;
               ram_wdata.right  = pr;
               ram_wdata.bottom = best_ent_ff.bottom;
            end else begin
               ram_wdata.left   = pr;
               ram_wdata.top    = best_ent_ff.top;
               ram_wdata.right  = best_ent_ff.right;
               ram_wdata.bottom = pb;
            end
            count_in = count_ff + CNT_W'(1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_x_in      = res_x_ff;
               rsp_y_in      = res_y_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = DATA_W'({rsp_y_ff, rsp_x_ff});

endmodule

[rtl/core/gra_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the free-rectangle list; depends on nothing.
module gra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[tb/testbench.sv]
// Self-checking testbench for guillotine_rect_allocator: directed and random pack and clear items
// over several bin sizes, with every result checked against an in-bench free-list predictor.
// Depends on gra_pkg and the allocator RTL only.
module testbench;
   import gra_pkg::*;

   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      req_kind_type kind;
      coord_type    w;
      coord_type    h;
   } alloc_item_type;

   typedef struct packed {
      status_type status;
      coord_type  x;
      coord_type  y;
   } placement_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_wr_en = 1'b0;
   logic                  csr_index = 1'b0;
   logic [COORD_BITS-1:0] csr_wdata = '0;

   alloc_item_type req_q[$];
   placement_type  placement_q[$];
   alloc_item_type req_cur;
   placement_type  got;
   placement_type  want;
   free_rect_type  free_rects[MAX_FREE];
   int             free_cnt;
   coord_type      bin_w_cfg = BIN_RESET;
   coord_type      bin_h_cfg = BIN_RESET;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             errors = 0;
   int             packs_sent = 0;
   int             clears_sent = 0;
   int             settings_run = 1;
   int             status_seen[4] = '{0, 0, 0, 0};
   int             stall_cycles = 0;

   guillotine_rect_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void reset_free_list();
      int i;
      for (i = 0; i < MAX_FREE; i++) begin
         free_rects[i] = '0;
      end
      free_rects[0].right  = bin_w_cfg;
      free_rects[0].bottom = bin_h_cfg;
      free_cnt = 1;
   endfunction

   // Best fit on leftover width, then leftover height; the earlier entry wins a tie.
   function automatic placement_type place_rect(input alloc_item_type item);
      placement_type res;
      logic       found;
      int         i;
      int         best;
      coord_type  fw, fh, rw, rh, best_rw, best_rh;
      coord_type  px, py, pr, pb, nl, nt, nr, nb;
      res = '{STATUS_PLACED, '0, '0};
      if (item.kind == REQ_CLEAR) begin
         reset_free_list();
         res.status = STATUS_CLEARED;
         return res;
      end
      found = 1'b0;
      best = 0;
      best_rw = '0;
      best_rh = '0;
      for (i = 0; i < free_cnt; i++) begin
         fw = free_rects[i].right - free_rects[i].left;
         fh = free_rects[i].bottom - free_rects[i].top;
         if (item.w <= fw && item.h <= fh) begin
            rw = fw - item.w;
            rh = fh - item.h;
            if (!found || rw < best_rw || (rw == best_rw && rh < best_rh)) begin
               found = 1'b1;
               best = i;
               best_rw = rw;
               best_rh = rh;
            end
         end
      end
      if (!found) begin
         res.status = STATUS_NOFIT;
         return res;
      end
      px = free_rects[best].left;
      py = free_rects[best].top;
      pr = px + item.w;
      pb = py + item.h;
      res.x = px;
      res.y = py;
      if (best_rw == 0 && best_rh == 0) begin
         for (i = best; i + 1 < free_cnt; i++) begin
            free_rects[i] = free_rects[i + 1];
         end
         free_cnt--;
      end else begin
         if (best_rw > best_rh) begin
            nl = px;
            nt = pb;
            nr = pr;
            nb = free_rects[best].bottom;
            free_rects[best].left = pr;
         end else begin
            nl = pr;
            nt = py;
            nr = free_rects[best].right;
            nb = pb;
            free_rects[best].top = pb;
         end
         if (best_rw != 0 && best_rh != 0) begin
            if (free_cnt < MAX_FREE) begin
               free_rects[free_cnt] = '{nl, nt, nr, nb};
               free_cnt++;
            end else begin
               res.status = STATUS_DROPPED;
            end
         end
      end
      return res;
   endfunction

   // Mostly small rectangles so the list grows and fills, with bin fractions for exact fits.
   function automatic alloc_item_type rand_item(input int bw, input int bh, input int clear_pct);
      alloc_item_type it;
      int             sel;
      sel = $urandom_range(0, 99);
      it.kind = REQ_PACK;
      if (sel < clear_pct) begin
         it.kind = REQ_CLEAR;
         it.w = coord_type'($urandom_range(0, 8191));
         it.h = coord_type'($urandom_range(0, 8191));
      end else if (sel < 60) begin
         it.w = coord_type'($urandom_range(0, bw / 8 + 1));
         it.h = coord_type'($urandom_range(0, bh / 8 + 1));
      end else if (sel < 75) begin
         it.w = coord_type'(bw >> $urandom_range(0, 3));
         it.h = coord_type'(bh >> $urandom_range(0, 3));
      end else if (sel < 85) begin
         it.w = coord_type'($urandom_range(0, 1) ? 0 : $urandom_range(0, bw / 4 + 1));
         it.h = (it.w == 0) ? coord_type'($urandom_range(0, bh / 4 + 1)) : coord_type'(0);
      end else if (sel < 95) begin
         it.w = coord_type'($urandom_range(0, 8191));
         it.h = coord_type'($urandom_range(0, 8191));
      end else begin
         it.w = coord_type'(bw);
         it.h = coord_type'(bh);
      end
      return it;
   endfunction

   task automatic add_req(input req_kind_type kind, input int w, input int h);
      alloc_item_type it;
      it.kind = kind;
      it.w = coord_type'(w);
      it.h = coord_type'(h);
      req_q = {req_q, it};
   endtask

   task automatic wait_idle();
      while (req_q.size() != 0 || req_tvalid || placement_q.size() != 0) begin
         @(negedge clock);
      end
      // Leave a quiet gap before the next phase.
      repeat (140) @(posedge clock);
   endtask

   task automatic write_bin(input int w, input int h);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_BIN_WIDTH;
      csr_wdata <= coord_type'(w);
      @(posedge clock);
      csr_index <= CSR_BIN_HEIGHT;
      csr_wdata <= coord_type'(h);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bin_w_cfg = coord_type'(w);
      bin_h_cfg = coord_type'(h);
   endtask

   task automatic random_phase(input int w, input int h, input int n, input int no_clear,
                               input int snd, input int rcv);
      int i;
      wait_idle();
      write_bin(w, h);
      @(negedge clock);
      send_idle_pct = snd;
      recv_idle_pct = rcv;
      settings_run++;
      add_req(REQ_CLEAR, 0, 0);
      for (i = 0; i < n; i++) begin
         req_q = {req_q, rand_item(w, h, (i < no_clear) ? 0 : 3)};
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            placement_q = {placement_q, place_rect(req_cur)};
            if (req_cur.kind == REQ_CLEAR) begin
               clears_sent++;
            end else begin
               packs_sent++;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_cur = req_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= req_cur.kind;
               req_tdata <= {{(DATA_W - 2 * COORD_BITS){1'b0}}, req_cur.h, req_cur.w};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tuser);
            got.x = rsp_tdata[COORD_BITS-1:0];
            got.y = rsp_tdata[2*COORD_BITS-1:COORD_BITS];
            if (placement_q.size() == 0) begin
               $display("%0t: unexpected item status %0d x %0d y %0d", $time,
                        got.status, got.x, got.y);
               errors++;
            end else begin
               want = placement_q.pop_front();
               if (got.status != want.status || got.x != want.x || got.y != want.y) begin
                  $display("%0t: expected status %0d x %0d y %0d, got status %0d x %0d y %0d",
                           $time, want.status, want.x, want.y, got.status, got.x, got.y);
                  errors++;
               end
            end
            status_seen[got.status]++;
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset_free_list();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 28;
      recv_idle_pct = 62;
      add_req(REQ_PACK, 0, 0);
      add_req(REQ_PACK, 1024, 1024);
      add_req(REQ_PACK, 1, 1);
      add_req(REQ_PACK, 0, 0);
      add_req(REQ_CLEAR, 8191, 8191);
      add_req(REQ_PACK, 4096, 4096);
      add_req(REQ_PACK, 8191, 8191);
      add_req(REQ_PACK, 1025, 1);
      add_req(REQ_PACK, 1024, 1);
      add_req(REQ_PACK, 1, 1023);
      add_req(REQ_PACK, 1023, 1);
      add_req(REQ_PACK, 0, 0);
      add_req(REQ_CLEAR, 0, 0);
      repeat (4) add_req(REQ_PACK, 512, 512);
      add_req(REQ_PACK, 1, 1);
      add_req(REQ_CLEAR, 0, 0);
      add_req(REQ_PACK, 0, 8191);
      add_req(REQ_PACK, 8191, 0);
      add_req(REQ_PACK, 1024, 1024);
      add_req(REQ_PACK, 0, 0);
      add_req(REQ_CLEAR, 0, 0);

      random_phase(4096, 4096, 110, 80, 28, 62);
      random_phase(64, 48, 110, 0, 62, 28);
      random_phase(1, 1, 30, 0, 62, 28);
      random_phase(0, 4096, 30, 0, 0, 0);
      random_phase(8191, 1, 40, 0, 0, 0);
      random_phase(300, 200, 110, 0, 0, 0);

      wait_idle();
      if (placement_q.size() != 0) begin
         $display("%0t: %0d expected items never arrived", $time, placement_q.size());
         errors++;
      end
      $display("Sent %0d packs and %0d clears over %0d bin settings.", packs_sent,
               clears_sent, settings_run);
      $display("Results: %0d placed, %0d with dropped leftover, %0d no fit, %0d cleared.",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
